// File: design/bipartite_max_matching_macros.svh
// Assertion macros shared by the matching block
`ifndef BIPARTITE_MAX_MATCHING_MACROS_SVH
`define BIPARTITE_MAX_MATCHING_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds
`define BMM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define BMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bmm_pkg.sv
// Package: item types, register indexes and constants of the matching block
package bmm_pkg;

    localparam int MAX_VERTS    = 64;
    localparam int RESULT_LIMIT = 64;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 7;
    localparam int COUNT_RESET  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_COUNT = 1'b1;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [5:0] left_index;
        logic [5:0] right_index;
        logic       edge_present;
    } t_in_item;

    typedef struct packed {
        logic [5:0] left_vertex;
        logic [5:0] partner;
        logic       matched;
        logic [6:0] match_count;
        logic       last;
    } t_out_item;

endpackage

// File: design/bmm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port
module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read; read data is registered and appears in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: design/bipartite_max_matching.sv
// Top level: Hopcroft-Karp maximum bipartite matching over an adjacency matrix
//
// Edge items set or clear one bit of the adjacency matrix and are taken one per
// cycle (a row read-modify-write with forwarding of the last written row); an
// empty matrix at reset comes from per-row valid bits, so there is no clearing
// pass. A run item starts from an empty matching and alternates a layering
// search and augmenting searches until no augmenting path remains, then gives
// one result per left vertex in use, the last one marked. A run takes a
// data-dependent time: each layering phase seeds the free left vertices,
// then for each dequeued vertex reads its row and layer, scans the right
// vertices and enqueues the mates of matched neighbors; each augmenting
// search scans the edges of its frames, pushes, pops and writes the parent
// frames back along the path; reporting waits out any output stall. The
// time is set by the single read port of each state memory (adjacency rows,
// layers, mates, queue and stack), read one vertex per cycle. No item is
// taken while a run is in progress.
module bipartite_max_matching #(
    parameter int MAX_VERTS = bmm_pkg::MAX_VERTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  bmm_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output bmm_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [bmm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bmm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

`include "bipartite_max_matching_macros.svh"

    localparam int VW = $clog2(MAX_VERTS);
    localparam int CW = $clog2(MAX_VERTS + 1);
    localparam int LW = $clog2(2 * MAX_VERTS + 4);
    localparam int FW = 2 * VW;

    typedef enum logic [4:0] {
        S_IDLE, S_BFS_SEED, S_BFS_POP, S_BFS_U, S_BFS_ROW, S_BFS_SCAN, S_BFS_MATE,
        S_BFS_END, S_ROOT, S_DFS_LOAD, S_DFS_SCAN, S_DFS_CHK, S_DFS_POP, S_AUG,
        S_OUT_RD, S_OUT_LD, S_OUT_WAIT
    } t_state;

    t_state r_state;

    // Configuration
    logic [bmm_pkg::CFG_DATA_W-1:0] r_left_count, r_right_count;

    // Edge write stage
    logic                 r_ew_valid;
    logic [VW-1:0]        r_ew_l, r_ew_r;
    logic                 r_ew_bit;
    logic                 r_fwd_valid;
    logic [VW-1:0]        r_fwd_l;
    logic [MAX_VERTS-1:0] r_fwd_row;
    logic [MAX_VERTS-1:0] r_adj_ok;
    logic                 r_adj_rok;

    // Run control
    logic [CW-1:0]        r_nl, r_nr, r_i, r_head, r_tail, r_v, r_sp, r_total;
    logic [VW-1:0]        r_u, r_k;
    logic [LW-1:0]        r_lu, r_fd;
    logic                 r_fd_found;
    logic [MAX_VERTS-1:0] r_row, r_rseen, r_lmatched, r_rmatched, r_visited;
    bmm_pkg::t_out_item   r_out;
    logic                 r_out_valid;

    // Memory ports
    logic                 adj_we;
    logic [VW-1:0]        adj_waddr, adj_raddr;
    logic [MAX_VERTS-1:0] adj_wdata, adj_rdata, adj_row;
    logic                 lm_we, rm_we, ll_we, rl_we, q_we, st_we;
    logic [VW-1:0]        lm_waddr, lm_raddr, lm_wdata, lm_rdata;
    logic [VW-1:0]        rm_waddr, rm_raddr, rm_wdata, rm_rdata;
    logic [VW-1:0]        ll_waddr, ll_raddr, rl_waddr, rl_raddr;
    logic [LW-1:0]        ll_wdata, ll_rdata, rl_wdata, rl_rdata;
    logic [VW-1:0]        q_waddr, q_raddr, q_wdata, q_rdata;
    logic [VW-1:0]        st_waddr, st_raddr;
    logic [FW-1:0]        st_wdata, st_rdata;

    // Derived values
    logic                 in_accept, edge_ok;
    logic [MAX_VERTS-1:0] ew_base, ew_row;
    logic [CW-1:0]        nl_run, nr_run, sp_m1, sp_m2;
    logic [VW-1:0]        v_idx, i_idx;
    logic [LW-1:0]        lu_p1, lu_p2;
    logic                 bfs_cand, dfs_cand, chk_ok, chk_free, chk_dead, chk_push;
    logic [VW-1:0]        fr_u, fr_v;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign edge_ok = (32'(i_in_data.left_index) < MAX_VERTS) &&
                     (32'(i_in_data.right_index) < MAX_VERTS);

    // Clamp the vertex counts for a run
    always_comb begin
        int lc;
        int rc;
        lc = int'(r_left_count);
        rc = int'(r_right_count);
        if (lc < 1) lc = 1;
        if (lc > MAX_VERTS) lc = MAX_VERTS;
        if (lc > bmm_pkg::RESULT_LIMIT) lc = bmm_pkg::RESULT_LIMIT;
        if (rc < 1) rc = 1;
        if (rc > MAX_VERTS) rc = MAX_VERTS;
        nl_run = CW'(lc);
        nr_run = CW'(rc);
    end

    // Unwritten rows read as empty; merge the pending edge bit
    assign adj_row = r_adj_rok ? adj_rdata : '0;
    always_comb begin
        ew_base = (r_fwd_valid && r_fwd_l == r_ew_l) ? r_fwd_row : adj_row;
        ew_row = ew_base;
        ew_row[r_ew_r] = r_ew_bit;
    end

    assign sp_m1 = r_sp - CW'(1);
    assign sp_m2 = r_sp - CW'(2);
    assign v_idx = r_v[VW-1:0];
    assign i_idx = r_i[VW-1:0];
    assign lu_p1 = r_lu + LW'(1);
    assign lu_p2 = r_lu + LW'(2);
    assign fr_u  = st_rdata[FW-1:VW];
    assign fr_v  = st_rdata[VW-1:0];

    assign bfs_cand = (r_v != r_nr) && r_row[v_idx] && !r_rseen[v_idx];
    assign dfs_cand = !r_visited[v_idx] && r_row[v_idx] && r_rseen[v_idx];
    assign chk_ok   = (rl_rdata == lu_p1);
    assign chk_free = !r_rmatched[v_idx];
    assign chk_dead = !chk_free && (rl_rdata == r_fd);
    assign chk_push = chk_ok && !chk_free && !chk_dead && (32'(r_sp) < MAX_VERTS);

    // Drive memory ports by state
    always_comb begin
        adj_we = r_ew_valid; adj_waddr = r_ew_l; adj_wdata = ew_row;
        adj_raddr = '0;
        lm_we = 1'b0; lm_waddr = '0; lm_wdata = '0; lm_raddr = '0;
        rm_we = 1'b0; rm_waddr = '0; rm_wdata = '0; rm_raddr = '0;
        ll_we = 1'b0; ll_waddr = '0; ll_wdata = '0; ll_raddr = '0;
        rl_we = 1'b0; rl_waddr = '0; rl_wdata = '0; rl_raddr = '0;
        q_we  = 1'b0; q_waddr  = '0; q_wdata  = '0; q_raddr  = '0;
        st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
        case (r_state)
            S_IDLE: begin
                adj_raddr = VW'(i_in_data.left_index);
            end
            S_BFS_SEED: begin
                if (r_i != r_nl && !r_lmatched[i_idx]) begin
                    q_we = 1'b1; q_waddr = r_tail[VW-1:0]; q_wdata = i_idx;
                    ll_we = 1'b1; ll_waddr = i_idx; ll_wdata = '0;
                end
            end
            S_BFS_POP: begin
                q_raddr = r_head[VW-1:0];
            end
            S_BFS_U: begin
                adj_raddr = q_rdata; ll_raddr = q_rdata;
            end
            S_BFS_SCAN: begin
                if (bfs_cand) begin
                    rl_we = 1'b1; rl_waddr = v_idx; rl_wdata = lu_p1;
                    rm_raddr = v_idx;
                end
            end
            S_BFS_MATE: begin
                ll_we = 1'b1; ll_waddr = rm_rdata; ll_wdata = lu_p2;
                q_we = 1'b1; q_waddr = r_tail[VW-1:0]; q_wdata = rm_rdata;
            end
            S_ROOT: begin
                adj_raddr = i_idx; ll_raddr = i_idx;
            end
            S_DFS_SCAN: begin
                if (r_v == r_nr) begin
                    st_raddr = sp_m2[VW-1:0];
                end else begin
                    rl_raddr = v_idx; rm_raddr = v_idx;
                end
            end
            S_DFS_CHK: begin
                if (chk_ok && chk_free) begin
                    lm_we = 1'b1; lm_waddr = r_u; lm_wdata = v_idx;
                    rm_we = 1'b1; rm_waddr = v_idx; rm_wdata = r_u;
                    st_raddr = sp_m2[VW-1:0];
                end else if (chk_push) begin
                    st_we = 1'b1; st_waddr = sp_m1[VW-1:0]; st_wdata = {r_u, v_idx};
                    adj_raddr = rm_rdata; ll_raddr = rm_rdata;
                end
            end
            S_DFS_POP: begin
                adj_raddr = fr_u; ll_raddr = fr_u;
            end
            S_AUG: begin
                lm_we = 1'b1; lm_waddr = fr_u; lm_wdata = fr_v;
                rm_we = 1'b1; rm_waddr = fr_v; rm_wdata = fr_u;
                st_raddr = r_k - VW'(1);
            end
            S_OUT_RD: begin
                lm_raddr = i_idx;
            end
            default: begin
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_count  <= bmm_pkg::CFG_DATA_W'(bmm_pkg::COUNT_RESET);
            r_right_count <= bmm_pkg::CFG_DATA_W'(bmm_pkg::COUNT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bmm_pkg::CFG_LEFT_COUNT:  r_left_count  <= i_cfg_data;
                bmm_pkg::CFG_RIGHT_COUNT: r_right_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Edge write stage: read row on accept, write merged row next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ew_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_adj_ok    <= '0;
            r_adj_rok   <= 1'b0;
        end else begin
            r_ew_valid <= in_accept && (i_in_data.kind == bmm_pkg::KIND_EDGE) && edge_ok;
            r_adj_rok  <= r_adj_ok[adj_raddr];
            if (r_ew_valid) begin
                r_fwd_valid       <= 1'b1;
                r_adj_ok[r_ew_l]  <= 1'b1;
            end
        end
        r_ew_l   <= VW'(i_in_data.left_index);
        r_ew_r   <= VW'(i_in_data.right_index);
        r_ew_bit <= i_in_data.edge_present;
        if (r_ew_valid) begin
            r_fwd_l   <= r_ew_l;
            r_fwd_row <= ew_row;
        end
    end

    // Run sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lmatched  <= '0;
            r_rmatched  <= '0;
            r_rseen     <= '0;
            r_visited   <= '0;
            r_fd_found  <= 1'b0;
            r_sp        <= '0;
            r_i         <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_v         <= '0;
            r_k         <= '0;
            r_total     <= '0;
            r_nl        <= '0;
            r_nr        <= '0;
            r_fd        <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept && i_in_data.kind == bmm_pkg::KIND_RUN) begin
                        r_nl       <= nl_run;
                        r_nr       <= nr_run;
                        r_lmatched <= '0;
                        r_rmatched <= '0;
                        r_total    <= '0;
                        r_head     <= '0;
                        r_tail     <= '0;
                        r_rseen    <= '0;
                        r_fd_found <= 1'b0;
                        r_i        <= '0;
                        r_state    <= S_BFS_SEED;
                    end
                end
                // Queue every free left vertex at layer zero
                S_BFS_SEED: begin
                    if (r_i == r_nl) begin
                        r_state <= S_BFS_POP;
                    end else begin
                        if (!r_lmatched[i_idx]) begin
                            r_tail <= r_tail + CW'(1);
                        end
                        r_i <= r_i + CW'(1);
                    end
                end
                S_BFS_POP: begin
                    if (r_head == r_tail) begin
                        r_state <= S_BFS_END;
                    end else begin
                        r_head  <= r_head + CW'(1);
                        r_state <= S_BFS_U;
                    end
                end
                S_BFS_U: begin
                    r_u     <= q_rdata;
                    r_state <= S_BFS_ROW;
                end
                // Stop once the queue passes the shortest free distance
                S_BFS_ROW: begin
                    r_row <= adj_row;
                    r_lu  <= ll_rdata;
                    r_v   <= '0;
                    if (r_fd_found && ll_rdata > r_fd) begin
                        r_state <= S_BFS_END;
                    end else begin
                        r_state <= S_BFS_SCAN;
                    end
                end
                // Layer each unseen neighbor; enqueue its mate
                S_BFS_SCAN: begin
                    if (r_v == r_nr) begin
                        r_state <= S_BFS_POP;
                    end else if (bfs_cand) begin
                        r_rseen[v_idx] <= 1'b1;
                        if (!r_rmatched[v_idx]) begin
                            r_fd       <= lu_p1;
                            r_fd_found <= 1'b1;
                            r_v        <= r_v + CW'(1);
                        end else begin
                            r_state <= S_BFS_MATE;
                        end
                    end else begin
                        r_v <= r_v + CW'(1);
                    end
                end
                S_BFS_MATE: begin
                    r_tail  <= r_tail + CW'(1);
                    r_v     <= r_v + CW'(1);
                    r_state <= S_BFS_SCAN;
                end
                S_BFS_END: begin
                    if (r_fd_found) begin
                        r_visited <= '0;
                        r_i       <= '0;
                        r_state   <= S_ROOT;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_OUT_RD;
                    end
                end
                // Start an augmenting search from each free left vertex
                S_ROOT: begin
                    if (r_i == r_nl) begin
                        r_head     <= '0;
                        r_tail     <= '0;
                        r_rseen    <= '0;
                        r_fd_found <= 1'b0;
                        r_i        <= '0;
                        r_state    <= S_BFS_SEED;
                    end else if (!r_lmatched[i_idx]) begin
                        r_u     <= i_idx;
                        r_v     <= '0;
                        r_sp    <= CW'(1);
                        r_state <= S_DFS_LOAD;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_DFS_LOAD: begin
                    r_row   <= adj_row;
                    r_lu    <= ll_rdata;
                    r_state <= S_DFS_SCAN;
                end
                // Try the next right vertex or pop the frame
                S_DFS_SCAN: begin
                    if (r_v == r_nr) begin
                        r_sp <= sp_m1;
                        if (r_sp == CW'(1)) begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_ROOT;
                        end else begin
                            r_state <= S_DFS_POP;
                        end
                    end else if (dfs_cand) begin
                        r_state <= S_DFS_CHK;
                    end else begin
                        r_v <= r_v + CW'(1);
                    end
                end
                S_DFS_CHK: begin
                    if (!chk_ok) begin
                        r_v     <= r_v + CW'(1);
                        r_state <= S_DFS_SCAN;
                    end else begin
                        r_visited[v_idx] <= 1'b1;
                        if (chk_free) begin
                            r_lmatched[r_u]   <= 1'b1;
                            r_rmatched[v_idx] <= 1'b1;
                            if (r_sp == CW'(1)) begin
                                r_total <= r_total + CW'(1);
                                r_i     <= r_i + CW'(1);
                                r_state <= S_ROOT;
                            end else begin
                                r_k     <= sp_m2[VW-1:0];
                                r_state <= S_AUG;
                            end
                        end else if (chk_push) begin
                            r_u     <= rm_rdata;
                            r_v     <= '0;
                            r_sp    <= r_sp + CW'(1);
                            r_state <= S_DFS_LOAD;
                        end else begin
                            r_v     <= r_v + CW'(1);
                            r_state <= S_DFS_SCAN;
                        end
                    end
                end
                // Resume the parent frame at its next right vertex
                S_DFS_POP: begin
                    r_u     <= fr_u;
                    r_v     <= CW'(fr_v) + CW'(1);
                    r_state <= S_DFS_LOAD;
                end
                // Flip the path one frame at a time
                S_AUG: begin
                    r_lmatched[fr_u] <= 1'b1;
                    r_rmatched[fr_v] <= 1'b1;
                    if (r_k == '0) begin
                        r_total <= r_total + CW'(1);
                        r_i     <= r_i + CW'(1);
                        r_state <= S_ROOT;
                    end else begin
                        r_k <= r_k - VW'(1);
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    r_out.left_vertex <= 6'(r_i);
                    r_out.partner     <= r_lmatched[i_idx] ? 6'(lm_rdata) : 6'd0;
                    r_out.matched     <= r_lmatched[i_idx];
                    r_out.match_count <= 7'(r_total);
                    r_out.last        <= (r_i == r_nl - CW'(1));
                    r_out_valid       <= 1'b1;
                    r_state           <= S_OUT_WAIT;
                end
                // Hold the item until taken
                S_OUT_WAIT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_i == r_nl - CW'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    bmm_ram #(.WIDTH(MAX_VERTS), .DEPTH(MAX_VERTS)) u_adj_ram (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );
    bmm_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS)) u_lmate_ram (
        .i_clk(i_clk), .i_we(lm_we), .i_waddr(lm_waddr), .i_wdata(lm_wdata),
        .i_raddr(lm_raddr), .o_rdata(lm_rdata)
    );
    bmm_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS)) u_rmate_ram (
        .i_clk(i_clk), .i_we(rm_we), .i_waddr(rm_waddr), .i_wdata(rm_wdata),
        .i_raddr(rm_raddr), .o_rdata(rm_rdata)
    );
    bmm_ram #(.WIDTH(LW), .DEPTH(MAX_VERTS)) u_llayer_ram (
        .i_clk(i_clk), .i_we(ll_we), .i_waddr(ll_waddr), .i_wdata(ll_wdata),
        .i_raddr(ll_raddr), .o_rdata(ll_rdata)
    );
    bmm_ram #(.WIDTH(LW), .DEPTH(MAX_VERTS)) u_rlayer_ram (
        .i_clk(i_clk), .i_we(rl_we), .i_waddr(rl_waddr), .i_wdata(rl_wdata),
        .i_raddr(rl_raddr), .o_rdata(rl_rdata)
    );
    bmm_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS)) u_queue_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );
    bmm_ram #(.WIDTH(FW), .DEPTH(MAX_VERTS)) u_stack_ram (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_rdata)
    );

    // Results appear only while input is held off
    `BMM_ASSERT_SAME(a_out_during_run, i_clk, i_rst_n, o_out_valid, o_in_stall, "result outside a run")
    // The matching never exceeds the left vertices in use
    `BMM_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, o_out_valid, (7'(r_nl) >= o_out_data.match_count), "match count too large")
    // The last result ends the run
    `BMM_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_out_data.last, !o_out_valid && !o_in_stall, "run did not end after last result")
    // Stack depth stays within the vertex count
    `BMM_ASSERT_SAME(a_stack_bound, i_clk, i_rst_n, 1'b1, (32'(r_sp) <= MAX_VERTS), "stack overflow")

endmodule
